[hw/rtl/dr_pkg.sv]
`default_nettype none
package dr_pkg;

    // Roll magnitude and divisor width, and the serial step counter
    localparam int MAG_W  = 16;
    localparam int DIV_W  = MAG_W + 1;
    localparam int STEP_W = $clog2(MAG_W + 1);

    // Dice count limit and the width of the roll counter
    localparam int MAX_DICE = 15;
    localparam int CNT_W    = $clog2(MAX_DICE + 1);

    // Opcodes
    localparam logic [2:0] OP_ROLL     = 3'd0;
    localparam logic [2:0] OP_INTERVAL = 3'd1;
    localparam logic [2:0] OP_DICE     = 3'd2;
    localparam logic [2:0] OP_TEMPLATE = 3'd3;
    localparam logic [2:0] OP_RESEED   = 3'd4;

    // Template side codes and the faces they stand for
    localparam logic [3:0] SIDE_CODE_D6  = 4'd1;
    localparam logic [3:0] SIDE_CODE_D20 = 4'd2;
    localparam logic [3:0] SIDE_CODE_D3  = 4'd3;
    localparam logic [DIV_W-1:0] FACES_D6  = DIV_W'(6);
    localparam logic [DIV_W-1:0] FACES_D20 = DIV_W'(20);
    localparam logic [DIV_W-1:0] FACES_D3  = DIV_W'(3);
    localparam logic [DIV_W-1:0] FACES_D4  = DIV_W'(4);

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } dr_mod_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] rem;
    } dr_mod_resp_t;

    typedef struct packed {
        logic             mix_we;
        logic [MAG_W-1:0] mix_value;
        logic             load;
        logic [MAG_W-1:0] load_value;
        logic             advance;
    } dr_seed_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/dr_mod.sv]
`default_nettype none
// Restoring remainder, one dividend bit per cycle
module dr_mod (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dr_pkg::dr_mod_req_t  req,
    output dr_pkg::dr_mod_resp_t      resp
);
    import dr_pkg::*;

    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W-1:0]  trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
            cnt_next  = STEP_W'(MAG_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next bit, subtract when it fits
            if (trial >= div_reg) begin
                rem_next = MAG_W'(trial - div_reg);
            end else begin
                rem_next = MAG_W'(trial);
            end
            quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign resp.done = done_reg;
    assign resp.rem  = rem_reg;

endmodule
`default_nettype wire

[hw/rtl/dr_seed.sv]
`default_nettype none
// Seed and mixing word, with the roll magnitude formed from both
module dr_seed (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dr_pkg::dr_seed_ctl_t  ctl,
    output logic [dr_pkg::MAG_W-1:0]   mag
);
    import dr_pkg::*;

    logic [MAG_W-1:0] seed_reg, seed_next;
    logic [MAG_W-1:0] mix_reg, mix_next;

    function automatic logic [MAG_W-1:0] roll_mag(input logic [MAG_W-1:0] s,
                                                 input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] r;
        x = s ^ m;
        r = {x[MAG_W-3:0], x[MAG_W-1:MAG_W-2]};
        r = r + m;
        x = r ^ s;
        r = {x[MAG_W-4:0], x[MAG_W-1:MAG_W-3]};
        // magnitude of r read as signed; the most negative code maps to itself
        if (r[MAG_W-1]) begin
            r = ~r + MAG_W'(1);
        end
        return r;
    endfunction

    assign mag = roll_mag(seed_reg, mix_reg);

    always_comb begin
        seed_next = seed_reg;
        mix_next  = mix_reg;
        if (ctl.mix_we) begin
            mix_next = ctl.mix_value;
        end
        if (ctl.load) begin
            seed_next = ctl.load_value;
        end else if (ctl.advance) begin
            seed_next = mag + MAG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            mix_reg  <= '0;
        end else begin
            seed_reg <= seed_next;
            mix_reg  <= mix_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/dice_roll_prng_engine.sv]
// Channel  | Direction | Handshake          | Contents
// ---------+-----------+--------------------+-----------------------------------
// s_       | in        | s_tvalid/s_tready  | one command item (opcode + operands)
// m_       | out       | m_tvalid/m_tready  | one result item per command
// cfg_     | in        | cfg_valid/cfg_ready| seed_mix write
//
// Rolls: a command makes up to MAX_DICE rolls; each roll with a nonzero
// divisor is set by the 16-step bit-serial remainder unit, a zero-divisor
// roll skips it.
// Reset: aresetn is synchronous, active low; clears seed, seed_mix and all
// handshake state.
// Stalls: a result waits in the output register; the next command is taken
// meanwhile, and the engine holds at its last step until the register frees.
`default_nettype none
module dice_roll_prng_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // dice_count[3:0], sides[18:4], bound_low[34:19],
                                       // bound_high[50:35], word[66:51], zero[71:67]
    input  wire logic [2:0]  s_tuser,  // opcode[2:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // value[15:0]
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data  // seed_mix[15:0]
);
    import dr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROLL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // unpack the command item
    logic [2:0]        in_opcode;
    logic [3:0]        in_dice_count;
    logic [14:0]       in_sides;
    logic [15:0]       in_bound_low;
    logic [15:0]       in_bound_high;
    logic [15:0]       in_word;

    assign in_opcode     = s_tuser;
    assign in_dice_count = s_tdata[3:0];
    assign in_sides      = s_tdata[18:4];
    assign in_bound_low  = s_tdata[34:19];
    assign in_bound_high = s_tdata[50:35];
    assign in_word       = s_tdata[66:51];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  rolls_reg, rolls_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [MAG_W-1:0]  off_reg, off_next;
    logic [MAG_W-1:0]  sum_reg, sum_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [MAG_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              accept;
    logic [DIV_W:0]    span;
    logic [DIV_W-1:0]  span_mag;
    logic [DIV_W-1:0]  tmpl_faces;
    logic [MAG_W-1:0]  mag;

    dr_mod_req_t       mod_req;
    dr_mod_resp_t      mod_resp;
    dr_seed_ctl_t      seed_ctl;

    // clamp a dice count to the limit
    function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] n);
        logic [8:0] wide;
        wide = {5'd0, n};
        if (wide > 9'(MAX_DICE)) begin
            return CNT_W'(MAX_DICE);
        end
        return CNT_W'(n);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // exact interval span hi - lo + 1 and its magnitude
    assign span     = {{2{in_bound_high[15]}}, in_bound_high}
                    - {{2{in_bound_low[15]}}, in_bound_low} + (DIV_W + 1)'(1);
    assign span_mag = span[DIV_W] ? DIV_W'(-span) : span[DIV_W-1:0];

    always_comb begin
        unique case (in_word[11:8])
            SIDE_CODE_D6:  tmpl_faces = FACES_D6;
            SIDE_CODE_D20: tmpl_faces = FACES_D20;
            SIDE_CODE_D3:  tmpl_faces = FACES_D3;
            default:       tmpl_faces = FACES_D4;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        rolls_next    = rolls_reg;
        div_next      = div_reg;
        off_next      = off_reg;
        sum_next      = sum_reg;
        m_tdata_next  = m_tdata_reg;
        // drop the result once taken
        m_tvalid_next = m_tvalid_reg && !m_tready;

        mod_req.start    = 1'b0;
        mod_req.dividend = mag;
        mod_req.divisor  = div_reg;

        seed_ctl.mix_we     = cfg_valid;
        seed_ctl.mix_value  = cfg_data;
        seed_ctl.load       = 1'b0;
        seed_ctl.load_value = in_word;
        seed_ctl.advance    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // every command becomes: sum of rolls plus an offset
                    sum_next   = '0;
                    state_next = ST_ROLL;
                    rolls_next = '0;
                    div_next   = '0;
                    off_next   = '0;
                    unique case (in_opcode)
                        OP_ROLL: begin
                            rolls_next = CNT_W'(1);
                            div_next   = {2'b00, in_sides};
                        end
                        OP_INTERVAL: begin
                            rolls_next = CNT_W'(1);
                            div_next   = span_mag;
                            off_next   = in_bound_low - MAG_W'(1);
                        end
                        OP_DICE: begin
                            rolls_next = clamp_count(in_dice_count);
                            div_next   = {2'b00, in_sides};
                            off_next   = in_bound_low;
                        end
                        OP_TEMPLATE: begin
                            rolls_next = clamp_count(in_word[15:12]);
                            div_next   = tmpl_faces;
                            off_next   = {{8{in_word[7]}}, in_word[7:0]};
                        end
                        OP_RESEED: begin
                            seed_ctl.load = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROLL: begin
                if (rolls_reg == '0) begin
                    state_next = ST_FIN;
                end else if (div_reg == '0) begin
                    // zero divisor: the roll adds nothing, seed holds
                    rolls_next = rolls_reg - CNT_W'(1);
                end else begin
                    // advance the seed and hand the magnitude to the divider
                    seed_ctl.advance = 1'b1;
                    mod_req.start    = 1'b1;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_resp.done) begin
                    sum_next   = sum_reg + mod_resp.rem + MAG_W'(1);
                    rolls_next = rolls_reg - CNT_W'(1);
                    state_next = ST_ROLL;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = sum_reg + off_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rolls_reg   <= rolls_next;
        div_reg     <= div_next;
        off_reg     <= off_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    dr_seed u_seed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (seed_ctl),
        .mag     (mag)
    );

    dr_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .resp    (mod_resp)
    );

endmodule
`default_nettype wire

[hw/rtl/dr_chk.sv]
`default_nettype none
module dr_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // one command at a time: the engine is busy after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while previous one still in work");

    // a new result only appears after the engine was busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind dice_roll_prng_engine dr_chk u_dr_chk (.*);
`default_nettype wire

[tb/dice_roll_prng_engine_tb.sv]
`timescale 1ns / 100ps

module dice_roll_prng_engine_tb;
    import dr_pkg::*;

    // One command item as the sender sees it, before packing onto the bus
    typedef struct {
        logic [2:0]  op;
        logic [3:0]  count;
        logic [14:0] sides;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] word;
    } dice_cmd_t;

    // One predicted result, tagged with the command that caused it
    typedef struct {
        logic [15:0] value;
        logic [2:0]  op;
        int          serial;
    } roll_expect_t;

    // Clock, reset and all block inputs start at known values
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;  // dice_count[3:0], sides[18:4], bound_low[34:19],
                                  // bound_high[50:35], word[66:51], zero[71:67]
    logic [2:0]  s_tuser   = '0;  // opcode[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;         // value[15:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;  // seed_mix[15:0]

    // Predictor state: the seed and the mixing word as the block should hold them
    logic [15:0] pred_seed = '0;
    logic [15:0] pred_mix  = '0;

    // Results still owed by the block, oldest first
    roll_expect_t pending_rolls[$];

    int err_count     = 0;
    int cmd_serial    = 0;
    int results_seen  = 0;
    int mix_settings  = 0;
    int op_hits[8];
    bit idle_on       = 1'b1;
    int stall_left    = 0;

    dice_roll_prng_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] rotl16(input logic [15:0] v, input int k);
        return (v << k) | (v >> (16 - k));
    endfunction

    // Raw 16-bit mix of a seed and a mixing word, before the magnitude is taken
    function automatic logic [15:0] raw_draw(input logic [15:0] s, input logic [15:0] m);
        logic [15:0] t;
        t = rotl16(s ^ m, 2);
        t = t + m;
        return rotl16(t ^ s, 3);
    endfunction

    // One die: a zero face count leaves the seed alone and yields zero
    function automatic logic [16:0] draw_roll(input logic [16:0] faces);
        logic [15:0] r;
        logic [16:0] mag;
        if (faces == '0)
            return '0;
        r = raw_draw(pred_seed, pred_mix);
        // |-32768| must come out as 32768, so work in 17 bits
        mag = r[15] ? (17'h10000 - {1'b0, r}) : {1'b0, r};
        pred_seed = mag[15:0] + 16'd1;
        return (mag % faces) + 17'd1;
    endfunction

    function automatic logic [15:0] sum_dice(input logic [3:0] count,
                                             input logic [16:0] faces,
                                             input logic [15:0] offset);
        logic [15:0] total;
        logic [16:0] one;
        int          n;
        total = '0;
        n = (count > MAX_DICE) ? MAX_DICE : count;
        for (int i = 0; i < n; i++) begin
            one = draw_roll(faces);
            total = total + one[15:0];
        end
        return total + offset;
    endfunction

    function automatic logic [15:0] predict_roll_value(input dice_cmd_t c);
        logic [15:0] v;
        logic [16:0] roll;
        logic [16:0] faces;
        int          lo_i;
        int          hi_i;
        int          span;
        v = '0;
        case (c.op)
            OP_ROLL: begin
                roll = draw_roll({2'b00, c.sides});
                v = roll[15:0];
            end
            OP_INTERVAL: begin
                lo_i = $signed(c.lo);
                hi_i = $signed(c.hi);
                span = hi_i - lo_i + 1;
                // the divisor is the magnitude of the exact span, up to 65536
                if (span < 0)
                    span = -span;
                roll = draw_roll(span[16:0]);
                v = c.lo + roll[15:0] - 16'd1;
            end
            OP_DICE: begin
                v = sum_dice(c.count, {2'b00, c.sides}, c.lo);
            end
            OP_TEMPLATE: begin
                case (c.word[11:8])
                    SIDE_CODE_D6:  faces = FACES_D6;
                    SIDE_CODE_D20: faces = FACES_D20;
                    SIDE_CODE_D3:  faces = FACES_D3;
                    default:       faces = FACES_D4;
                endcase
                v = sum_dice(c.word[15:12], faces, {{8{c.word[7]}}, c.word[7:0]});
            end
            OP_RESEED: begin
                pred_seed = c.word;
            end
            default: begin
                // spare opcodes: zero result, state untouched
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int serial,
                                   input logic [15:0] got, input logic [15:0] want);
        $display("MISMATCH %s: item %0d got %h want %h", what, serial, got, want);
        err_count++;
    endtask

    function automatic dice_cmd_t make_cmd(input logic [2:0] op, input logic [3:0] count,
                                           input logic [14:0] sides, input logic [15:0] lo,
                                           input logic [15:0] hi, input logic [15:0] word);
        dice_cmd_t c;
        c.op = op;
        c.count = count;
        c.sides = sides;
        c.lo = lo;
        c.hi = hi;
        c.word = word;
        return c;
    endfunction

    // Send one command item; predict its result at the edge that accepts it
    task automatic send_cmd(input dice_cmd_t c);
        int           gap;
        roll_expect_t e;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, c.word, c.hi, c.lo, c.sides, c.count};
        s_tuser  <= c.op;
        do @(posedge aclk); while (s_tready !== 1'b1);
        e.value  = predict_roll_value(c);
        e.op     = c.op;
        e.serial = cmd_serial;
        cmd_serial++;
        op_hits[c.op]++;
        pending_rolls.push_back(e);
    endtask

    // Hold the sender off until every owed result has been taken
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_rolls.size() != 0) @(posedge aclk);
    endtask

    // Write seed_mix; only ever done with the engine idle
    task automatic write_mix(input logic [15:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        pred_mix = v;
        mix_settings++;
    endtask

    // Random command: mostly well-formed operands per opcode, some noise
    function automatic dice_cmd_t random_cmd();
        dice_cmd_t c;
        int        pick;
        int        k;
        c.op    = 3'($urandom_range(0, 7));
        c.count = 4'($urandom);
        c.sides = 15'($urandom);
        c.lo    = 16'($urandom);
        c.hi    = 16'($urandom);
        c.word  = 16'($urandom);
        pick = $urandom_range(0, 99);
        // keep face counts small most of the time, with zero and the top now and then
        k = $urandom_range(0, 9);
        if (k == 0)
            c.sides = '0;
        else if (k <= 6)
            c.sides = 15'($urandom_range(1, 40));
        else if (k == 9)
            c.sides = 15'h7fff;
        if (pick < 15) begin
            c.op = OP_ROLL;
        end else if (pick < 35) begin
            c.op = OP_INTERVAL;
            k = $urandom_range(0, 9);
            if (k <= 5)
                c.hi = c.lo + 16'($urandom_range(0, 63));
            else if (k == 6)
                c.hi = c.lo - 16'd1;
            else if (k == 7)
                c.hi = c.lo - 16'($urandom_range(2, 63));
        end else if (pick < 55) begin
            c.op = OP_DICE;
            if ($urandom_range(0, 9) < 7)
                c.lo = 16'($urandom_range(0, 40)) - 16'd20;
        end else if (pick < 80) begin
            c.op = OP_TEMPLATE;
        end else if (pick < 90) begin
            c.op = OP_RESEED;
        end else if (pick < 95) begin
            c.op = 3'($urandom_range(int'(OP_RESEED) + 1, 7));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------

    // Stall in random bursts while idling is on; otherwise take every result
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        roll_expect_t e;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_rolls.size() == 0) begin
                report_mismatch("unexpected result", -1, m_tdata, 16'h0000);
            end else begin
                e = pending_rolls.pop_front();
                results_seen++;
                if (m_tdata !== e.value)
                    report_mismatch($sformatf("value op %0d", e.op), e.serial, m_tdata,
                                    e.value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    task automatic test_single_roll();
        // zero faces first: seed must stay at its reset value
        send_cmd(make_cmd(OP_ROLL, 4'hf, 15'd0, 16'hffff, 16'hffff, 16'hffff));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'd1, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'h7fff, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'd6, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_interval_roll();
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'd1, 16'd6, 16'h0000));
        // full span: divisor of 65536
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'h8000, 16'h7fff, 16'h0000));
        // empty span (hi one below lo): zero roll, seed untouched
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'd5, 16'd4, 16'h0000));
        // reversed interval at the extremes, result wraps
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'h7fff, 16'h8000, 16'h0000));
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'h8000, 16'h8000, 16'h0000));
    endtask

    task automatic test_dice_sum();
        send_cmd(make_cmd(OP_DICE, 4'h0, 15'd6, 16'hffff, 16'h0000, 16'h0000));
        // most dice, most faces, top offset: sum wraps
        send_cmd(make_cmd(OP_DICE, 4'hf, 15'h7fff, 16'h7fff, 16'h0000, 16'h0000));
        send_cmd(make_cmd(OP_DICE, 4'hf, 15'd0, 16'h8000, 16'h0000, 16'h0000));
    endtask

    task automatic test_template_dice();
        send_cmd(make_cmd(OP_TEMPLATE, 4'h0, 15'd0, 16'h0000, 16'h0000,
                          {4'd3, SIDE_CODE_D6, 8'h05}));
        send_cmd(make_cmd(OP_TEMPLATE, 4'h0, 15'd0, 16'h0000, 16'h0000,
                          {4'd2, SIDE_CODE_D20, 8'h80}));
        send_cmd(make_cmd(OP_TEMPLATE, 4'h0, 15'd0, 16'h0000, 16'h0000,
                          {4'hf, SIDE_CODE_D3, 8'h7f}));
        // side codes outside the named ones fall back to four faces
        send_cmd(make_cmd(OP_TEMPLATE, 4'h0, 15'd0, 16'h0000, 16'h0000,
                          {4'h0, 4'h0, 8'h01}));
        send_cmd(make_cmd(OP_TEMPLATE, 4'h0, 15'd0, 16'h0000, 16'h0000, 16'hffff));
    endtask

    task automatic test_reseed_and_spare_ops();
        send_cmd(make_cmd(OP_RESEED, 4'h0, 15'd0, 16'h0000, 16'h0000, 16'hffff));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'h7fff, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(OP_RESEED, 4'hf, 15'h7fff, 16'hffff, 16'hffff, 16'h0000));
        // spare opcodes with every operand bit set: zero out, nothing moves
        for (int k = int'(OP_RESEED) + 1; k < 8; k++)
            send_cmd(make_cmd(3'(k), 4'hf, 15'h7fff, 16'hffff, 16'hffff, 16'hffff));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'd20, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Find a seed and mixing word whose raw draw is 0x8000, so the magnitude is 32768
    task automatic test_most_negative_draw();
        logic [15:0] m;
        logic [15:0] s;
        bit          found;
        found = 1'b0;
        m = 16'd1;
        s = '0;
        for (int mi = 1; mi < 256 && !found; mi++) begin
            for (int si = 0; si < 65536 && !found; si++) begin
                if (raw_draw(16'(si), 16'(mi)) == 16'h8000) begin
                    found = 1'b1;
                    m = 16'(mi);
                    s = 16'(si);
                end
            end
        end
        write_mix(m);
        send_cmd(make_cmd(OP_RESEED, 4'h0, 15'd0, 16'h0000, 16'h0000, s));
        send_cmd(make_cmd(OP_ROLL, 4'h0, 15'h7fff, 16'h0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(OP_RESEED, 4'h0, 15'd0, 16'h0000, 16'h0000, s));
        send_cmd(make_cmd(OP_INTERVAL, 4'h0, 15'd0, 16'h8000, 16'h7fff, 16'h0000));
    endtask

    // ------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------

    task automatic test_random_phase(input logic [15:0] mix, input int count,
                                     input bit idling);
        dice_cmd_t c;
        // the write drains the engine first, so the sender pauses until every owed result is taken
        write_mix(mix);
        idle_on = idling;
        for (int i = 0; i < count; i++) begin
            c = random_cmd();
            send_cmd(c);
            // now and then let the engine run dry mid-phase
            if ($urandom_range(0, 149) == 0)
                wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // hold reset from the start, then release it on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part runs with the reset value of seed_mix first
        test_single_roll();
        test_interval_roll();
        test_dice_sum();
        test_template_dice();
        test_reseed_and_spare_ops();
        test_most_negative_draw();

        // random part: extremes of seed_mix plus random settings
        test_random_phase(16'hffff, 300, 1'b1);
        test_random_phase(16'h0000, 300, 1'b1);
        test_random_phase(16'h8000, 300, 1'b0);
        test_random_phase(16'($urandom), 300, 1'b1);
        test_random_phase(16'h0001, 300, 1'b1);
        test_random_phase(16'($urandom), 200, 1'b1);
        // last stretch with no idling on either side
        test_random_phase(16'($urandom), 100, 1'b0);

        // drop valid, wait out every owed result, then give the engine time to misbehave
        wait_drain();
        repeat (300) @(posedge aclk);

        $display("Ran %0d items: roll %0d, interval %0d, dice %0d, template %0d, reseed %0d",
                 cmd_serial, op_hits[OP_ROLL], op_hits[OP_INTERVAL], op_hits[OP_DICE],
                 op_hits[OP_TEMPLATE], op_hits[OP_RESEED]);
        $display("Spare opcodes %0d, %0d seed_mix writes, %0d results checked, %0d errors",
                 cmd_serial - op_hits[OP_ROLL] - op_hits[OP_INTERVAL] - op_hits[OP_DICE]
                 - op_hits[OP_TEMPLATE] - op_hits[OP_RESEED],
                 mix_settings, results_seen, err_count);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #30_000_000;
        $display("TIMEOUT with %0d results still owed", pending_rolls.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
